### src/rtdsu_pkg.sv
package rtdsu_pkg;

	// Default number of task slots.
	localparam int TASK_SLOTS_DEF = 16;

	// Largest prescaler divisor that is honoured.
	localparam int DIV_MAX = 1024;

	// Widths fixed by the interface.
	localparam int DIV_W   = 11;
	localparam int PRESC_W = 10;
	localparam int INDEX_W = 4;
	localparam int DELAY_W = 32;
	localparam int PRIO_W  = 8;
	localparam int SLICE_W = 16;
	localparam int MODE_W  = 2;
	localparam int EVENT_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PULSE  = 2'd0,
		MODE_DELAY  = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_SLICE  = 2'd3
	} mode_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_DONE   = 2'd0,
		EV_WOKEN  = 2'd1,
		EV_SWITCH = 2'd2
	} event_t;

endpackage

### src/rtdsu_delay_ram.sv
module rtdsu_delay_ram #(
	parameter int TASK_SLOTS = rtdsu_pkg::TASK_SLOTS_DEF,
	parameter int SLOT_W     = $clog2(TASK_SLOTS)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [SLOT_W-1:0]            wr_addr,
	input  logic [rtdsu_pkg::DELAY_W-1:0] wr_delay,
	input  logic [rtdsu_pkg::PRIO_W-1:0]  wr_prio,
	input  logic [SLOT_W-1:0]            rd_addr,
	output logic [rtdsu_pkg::DELAY_W-1:0] rd_delay,
	output logic [rtdsu_pkg::PRIO_W-1:0]  rd_prio
);
	import rtdsu_pkg::*;

	// Remaining delay and stored priority of every slot, one word per slot.
	logic [DELAY_W-1:0] delay_mem [TASK_SLOTS];
	logic [PRIO_W-1:0]  prio_mem  [TASK_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			delay_mem[wr_addr] <= wr_delay;
			prio_mem[wr_addr]  <= wr_prio;
		end
		rd_delay <= delay_mem[rd_addr];
		rd_prio  <= prio_mem[rd_addr];
	end

endmodule

### src/rtos_tick_delay_and_slice_unit.sv
// Kernel tick unit: prescaler, running-task time slice and per-slot task delays.
//
// Commands are issued on start together with mode and its operand fields; a
// transaction is taken at a rising edge with start high and busy low. Modes are
// a clock pulse, start of a task delay, cancel of a task delay and a load of the
// time slice. The divisor tick_divide is written through the cfg channel, which
// accepts a write whenever the unit is idle.
//
// Every command returns results on result_valid, one per cycle, each present for
// exactly one cycle; the receiver cannot hold them off. The final result of a
// command has event_kind done and last set. A clock pulse that passes the
// prescaler first may report one slice-expired switch request and then one woken
// report per slot whose delay runs out, in ascending slot order.
//
// A delay, cancel or slice command, or a pulse swallowed by the prescaler, passes
// through the decode and finish states. A processed tick adds the slot sweep
// between them: one delay memory read port and one write port serve one slot per
// cycle through a single shared decrement-and-compare unit.
// Reset clears all delays, the slice, the prescaler and sets the divisor to 1.
module rtos_tick_delay_and_slice_unit #(
	parameter int TASK_SLOTS = rtdsu_pkg::TASK_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rtdsu_pkg::MODE_W-1:0]  mode,
	input  logic [rtdsu_pkg::INDEX_W-1:0] task_index,
	input  logic [rtdsu_pkg::DELAY_W-1:0] delay_ticks,
	input  logic [rtdsu_pkg::PRIO_W-1:0]  task_priority,
	input  logic [rtdsu_pkg::SLICE_W-1:0] slice_ticks,
	input  logic                          switch_ready,
	input  logic                          in_interrupt,
	input  logic [rtdsu_pkg::PRIO_W-1:0]  running_priority,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtdsu_pkg::DIV_W-1:0]   cfg_data,
	output logic                          result_valid,
	output logic [rtdsu_pkg::EVENT_W-1:0] event_kind,
	output logic [rtdsu_pkg::INDEX_W-1:0] woken_task,
	output logic                          preempt,
	output logic                          last
);
	import rtdsu_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CNT_W  = SLOT_W + 1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [DIV_W-1:0]    tick_divide_q;
	logic [PRESC_W-1:0]  prescale_q;
	logic [SLICE_W-1:0]  slice_q;
	logic [TASK_SLOTS-1:0] delayed_q;

	// Captured command fields.
	mode_t               mode_q;
	logic [INDEX_W-1:0]  index_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [SLICE_W-1:0]  slice_ld_q;
	logic                ready_q;
	logic                irq_q;
	logic [PRIO_W-1:0]   run_prio_q;

	// Sweep: read issue counter and the stage that holds the read data.
	cnt_t                cnt_q;
	logic                vld_s1;
	slot_t               idx_s1;

	// Registered results.
	logic                res_valid_q;
	event_t              event_q;
	logic [INDEX_W-1:0]  woken_q;
	logic                preempt_q;
	logic                last_q;

	logic                accept;
	logic [DIV_W-1:0]    div_eff;
	logic [DIV_W-1:0]    presc_next;
	logic                tick;
	logic                in_range;
	slot_t               cmd_slot;
	slot_t               cnt_slot;
	logic                issue;
	logic                sweep_end;
	logic [DELAY_W-1:0]  rd_delay;
	logic [PRIO_W-1:0]   rd_prio;
	logic [DELAY_W-1:0]  dec;
	logic                dec_zero;
	logic                ram_we;
	slot_t               ram_waddr;
	logic [DELAY_W-1:0]  ram_wdelay;
	logic [PRIO_W-1:0]   ram_wprio;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	// Divisor clamped to the range one to DIV_MAX.
	always_comb begin
		priority if (tick_divide_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (tick_divide_q > DIV_W'(DIV_MAX)) begin
			div_eff = DIV_W'(DIV_MAX);
		end else begin
			div_eff = tick_divide_q;
		end
	end

	assign presc_next = {1'b0, prescale_q} + DIV_W'(1);
	assign tick       = (presc_next >= div_eff);

	assign in_range  = (32'(index_q) < TASK_SLOTS);
	assign cmd_slot  = slot_t'(index_q);
	assign cnt_slot  = cnt_q[SLOT_W-1:0];
	assign sweep_end = (cnt_q == cnt_t'(TASK_SLOTS));
	assign issue     = (state_q == ST_SWEEP) && !sweep_end && delayed_q[cnt_slot];

	// The one shared decrement-and-compare unit of the sweep.
	assign dec      = rd_delay - DELAY_W'(1);
	assign dec_zero = (dec == '0);

	always_comb begin
		if (vld_s1) begin
			ram_we     = 1'b1;
			ram_waddr  = idx_s1;
			ram_wdelay = dec;
			ram_wprio  = rd_prio;
		end else begin
			ram_we     = (state_q == ST_DECODE) && (mode_q == MODE_DELAY) && in_range;
			ram_waddr  = cmd_slot;
			ram_wdelay = delay_q;
			ram_wprio  = prio_q;
		end
	end

	rtdsu_delay_ram #(
		.TASK_SLOTS(TASK_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_delay(ram_wdelay),
		.wr_prio (ram_wprio),
		.rd_addr (cnt_slot),
		.rd_delay(rd_delay),
		.rd_prio (rd_prio)
	);

	// Command fields are held for the whole transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode_t'(mode);
			index_q    <= task_index;
			delay_q    <= delay_ticks;
			prio_q     <= task_priority;
			slice_ld_q <= slice_ticks;
			ready_q    <= switch_ready;
			irq_q      <= in_interrupt;
			run_prio_q <= running_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tick_divide_q <= DIV_W'(1);
			prescale_q    <= '0;
			slice_q       <= '0;
			delayed_q     <= '0;
			cnt_q         <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			res_valid_q   <= 1'b0;
			event_q       <= EV_DONE;
			woken_q       <= '0;
			preempt_q     <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			event_q     <= EV_DONE;
			woken_q     <= '0;
			preempt_q   <= 1'b0;
			last_q      <= 1'b0;
			vld_s1      <= issue;
			idx_s1      <= cnt_slot;

			if (cfg_valid && cfg_ready) begin
				tick_divide_q <= cfg_data;
			end

			// A slot whose delay runs out is cleared and reported.
			if (vld_s1 && dec_zero) begin
				delayed_q[idx_s1] <= 1'b0;
				res_valid_q       <= 1'b1;
				event_q           <= EV_WOKEN;
				woken_q           <= INDEX_W'(idx_s1);
				preempt_q         <= ready_q && (rd_prio < run_prio_q);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_FINISH;
					cnt_q   <= '0;
					unique case (mode_q)
						MODE_PULSE: begin
							if (tick) begin
								prescale_q <= '0;
								state_q    <= ST_SWEEP;
								if (slice_q != '0 && ready_q && !irq_q) begin
									slice_q <= slice_q - SLICE_W'(1);
									if (slice_q == SLICE_W'(1)) begin
										res_valid_q <= 1'b1;
										event_q     <= EV_SWITCH;
									end
								end
							end else begin
								prescale_q <= presc_next[PRESC_W-1:0];
							end
						end
						MODE_DELAY: begin
							if (in_range) begin
								delayed_q[cmd_slot] <= (delay_q != '0);
							end
						end
						MODE_CANCEL: begin
							if (in_range) begin
								delayed_q[cmd_slot] <= 1'b0;
							end
						end
						MODE_SLICE: begin
							slice_q <= slice_ld_q;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_SWEEP: begin
					if (!sweep_end) begin
						cnt_q <= cnt_q + cnt_t'(1);
					end else if (!vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
					event_q     <= EV_DONE;
					last_q      <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign event_kind   = event_q;
	assign woken_task   = woken_q;
	assign preempt      = preempt_q;
	assign last         = last_q;

endmodule

### src/rtdsu_checker.sv
module rtdsu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_valid,
	input logic [rtdsu_pkg::EVENT_W-1:0] event_kind,
	input logic                          preempt,
	input logic                          last
);
	import rtdsu_pkg::*;

	// An accepted command keeps the unit busy until its results are out.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// The final result appears exactly as the unit falls idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last)
		else $error("unit went idle without a final result");

	// Intermediate results only occur while a command is in progress.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("intermediate result while idle");

	// The final result is always a plain completion.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> event_kind == EV_DONE && !preempt)
		else $error("final result is not a completion");

	// Preemption is only flagged on woken reports.
	a_preempt_woken: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && preempt |-> event_kind == EV_WOKEN)
		else $error("preempt set on a non-wake result");

endmodule

bind rtos_tick_delay_and_slice_unit rtdsu_checker u_rtdsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.event_kind  (event_kind),
	.preempt     (preempt),
	.last        (last)
);
